// ===== src/pipc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pipc_pkg;

    // Per-vertex flags that travel from the front end to the crossing unit
    typedef struct packed {
        logic first;           // vertex opens a polygon: restart parity
        logic last;            // vertex closes a polygon: emit a result
        logic open_straddle;   // edge to the previous vertex straddles the query y
        logic close_straddle;  // closing edge to the first vertex straddles the query y
    } pipc_ctrl_t;

endpackage

`default_nettype wire

// ===== src/pipc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pipc_front
    import pipc_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_BITS-1:0]  s_vertex_x,
    input  wire logic signed [COORD_BITS-1:0]  s_vertex_y,
    input  wire logic signed [COORD_BITS-1:0]  s_point_x,
    input  wire logic signed [COORD_BITS-1:0]  s_point_y,
    input  wire logic                          s_last_vertex,
    input  wire logic                          q_ready,
    output logic                               q_push,
    output pipc_ctrl_t                         q_ctrl,
    output logic [6*(COORD_BITS+1)-1:0]        q_data
);

    localparam int DW = COORD_BITS + 1;

    logic                          mid_reg;
    logic signed [COORD_BITS-1:0]  query_px_reg, query_py_reg;
    logic signed [COORD_BITS-1:0]  first_vx_reg, first_vy_reg;
    logic signed [COORD_BITS-1:0]  prev_vx_reg, prev_vy_reg;

    logic signed [COORD_BITS-1:0]  qx, qy, fx, fy;
    logic                          v_above, prev_above, first_above;
    logic signed [DW-1:0]          dqx, dqy, dy_open, dbx_open, dy_close, dbx_close;

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

    // A first vertex brings its own query point and is its own first vertex
    always_comb begin
        qx = mid_reg ? query_px_reg : s_point_x;
        qy = mid_reg ? query_py_reg : s_point_y;
        fx = mid_reg ? first_vx_reg : s_vertex_x;
        fy = mid_reg ? first_vy_reg : s_vertex_y;
    end

    always_comb begin
        v_above     = s_vertex_y > qy;
        prev_above  = prev_vy_reg > qy;
        first_above = fy > qy;
    end

    always_comb begin
        dqx       = {qx[COORD_BITS-1], qx} - {s_vertex_x[COORD_BITS-1], s_vertex_x};
        dqy       = {qy[COORD_BITS-1], qy} - {s_vertex_y[COORD_BITS-1], s_vertex_y};
        dy_open   = {prev_vy_reg[COORD_BITS-1], prev_vy_reg}
                    - {s_vertex_y[COORD_BITS-1], s_vertex_y};
        dbx_open  = {prev_vx_reg[COORD_BITS-1], prev_vx_reg}
                    - {s_vertex_x[COORD_BITS-1], s_vertex_x};
        dy_close  = {fy[COORD_BITS-1], fy} - {s_vertex_y[COORD_BITS-1], s_vertex_y};
        dbx_close = {fx[COORD_BITS-1], fx} - {s_vertex_x[COORD_BITS-1], s_vertex_x};
    end

    always_comb begin
        q_ctrl.first          = !mid_reg;
        q_ctrl.last           = s_last_vertex;
        q_ctrl.open_straddle  = mid_reg && (v_above != prev_above);
        q_ctrl.close_straddle = s_last_vertex && (v_above != first_above);
        q_data = {dqx, dqy, dy_open, dbx_open, dy_close, dbx_close};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg <= 1'b0;
        end else if (q_push) begin
            mid_reg <= !s_last_vertex;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            if (!mid_reg) begin
                query_px_reg <= s_point_x;
                query_py_reg <= s_point_y;
                first_vx_reg <= s_vertex_x;
                first_vy_reg <= s_vertex_y;
            end
            prev_vx_reg <= s_vertex_x;
            prev_vy_reg <= s_vertex_y;
        end
    end

    // A straddling edge has end points at different heights
    a_open_dy : assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_ctrl.open_straddle) |-> (dy_open != '0))
        else $error("open edge straddles with zero height");

    a_close_dy : assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_ctrl.close_straddle) |-> (dy_close != '0))
        else $error("closing edge straddles with zero height");

endmodule

`default_nettype wire

// ===== src/pipc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pipc_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_push,
    output logic               in_ready,
    input  wire logic [W-1:0]  in_data,
    output logic               out_valid,
    input  wire logic          out_pop,
    output logic [W-1:0]       out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [W-1:0]   entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign in_ready  = count_reg != FULL_CNT;
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (out_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (in_push && !out_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!in_push && out_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_no_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        in_push |-> (count_reg != FULL_CNT))
        else $error("queue push while full");

    a_no_underflow : assert property (@(posedge aclk) disable iff (!aresetn)
        out_pop |-> (count_reg != '0))
        else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== src/pipc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pipc_back
    import pipc_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_valid,
    output logic                              q_pop,
    input  wire pipc_ctrl_t                   q_ctrl,
    input  wire logic [6*(COORD_BITS+1)-1:0]  q_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_inside_res
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0]  dqx, dqy, dy_open, dbx_open, dy_close, dbx_close;
    logic signed [PW-1:0]  lhs_open, rhs_open, lhs_close, rhs_close;

    logic                  s1_valid_reg;
    pipc_ctrl_t            s1_ctrl_reg;
    logic signed [PW-1:0]  lhs_open_reg, rhs_open_reg, lhs_close_reg, rhs_close_reg;
    logic                  dy_open_neg_reg, dy_close_neg_reg;

    logic                  s1_adv;
    logic                  tog_open, tog_close;
    logic                  parity_reg, parity_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  inside_reg;

    always_comb begin
        {dqx, dqy, dy_open, dbx_open, dy_close, dbx_close} = q_data;
    end

    // Cross-multiplied crossing test: (qx-ax)*dy against (bx-ax)*(qy-ay)
    always_comb begin
        lhs_open  = dqx * dy_open;
        rhs_open  = dbx_open * dqy;
        lhs_close = dqx * dy_close;
        rhs_close = dbx_close * dqy;
    end

    // Hold a closing vertex while the result register is still occupied
    assign s1_adv = s1_valid_reg && (!s1_ctrl_reg.last || !m_valid_reg || m_ready);
    assign q_pop  = q_valid && (!s1_valid_reg || s1_adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (!s1_valid_reg || s1_adv) begin
            s1_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_ctrl_reg      <= q_ctrl;
            lhs_open_reg     <= lhs_open;
            rhs_open_reg     <= rhs_open;
            lhs_close_reg    <= lhs_close;
            rhs_close_reg    <= rhs_close;
            dy_open_neg_reg  <= dy_open[DW-1];
            dy_close_neg_reg <= dy_close[DW-1];
        end
    end

    always_comb begin
        tog_open  = s1_ctrl_reg.open_straddle
                    && (dy_open_neg_reg ? (rhs_open_reg < lhs_open_reg)
                                        : (lhs_open_reg < rhs_open_reg));
        tog_close = s1_ctrl_reg.close_straddle
                    && (dy_close_neg_reg ? (rhs_close_reg < lhs_close_reg)
                                         : (lhs_close_reg < rhs_close_reg));
        parity_next = (s1_ctrl_reg.first ? 1'b0 : parity_reg) ^ tog_open ^ tog_close;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv && s1_ctrl_reg.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s1_adv) begin
                parity_reg <= parity_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_ctrl_reg.last) begin
            inside_reg <= parity_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = inside_reg;

    // A new result only comes from a closing vertex leaving the product stage
    a_result_source : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_adv && s1_ctrl_reg.last))
        else $error("result raised without a closing vertex");

    a_stage_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_ctrl_reg.last && m_valid_reg && !m_ready) |-> !q_pop)
        else $error("queue popped while closing vertex is blocked");

endmodule

`default_nettype wire

// ===== src/point_in_polygon_crossing_test_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Even-odd ray-crossing point-in-polygon test on signed Q16.16 coordinates.
// Stream the vertices of a polygon one per transfer; the query point is taken
// from the first vertex of each polygon and ignored on the others, and
// last_vertex marks the final vertex, on which the closing edge is tested and
// one inside/outside result is emitted. The core takes one vertex per clock
// cycle while the queue has room. After the last vertex is accepted it passes
// through the queue and the registered products of the four multipliers (two
// per edge, COORD_BITS+1 bits square) before m_valid rises; the result then
// waits in the output register until it is taken. The queue of QUEUE_DEPTH
// entries lets the input keep flowing while a result waits to be taken.
module point_in_polygon_crossing_test_core
    import pipc_pkg::*;
#(
    parameter int COORD_BITS  = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_BITS-1:0]  s_vertex_x,
    input  wire logic signed [COORD_BITS-1:0]  s_vertex_y,
    input  wire logic signed [COORD_BITS-1:0]  s_point_x,
    input  wire logic signed [COORD_BITS-1:0]  s_point_y,
    input  wire logic                          s_last_vertex,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_inside_res
);

    localparam int DATA_W = 6 * (COORD_BITS + 1);
    localparam int CTRL_W = $bits(pipc_ctrl_t);
    localparam int QW     = CTRL_W + DATA_W;

    logic                q_ready, q_push, q_valid, q_pop;
    pipc_ctrl_t          push_ctrl, pop_ctrl;
    logic [DATA_W-1:0]   push_data, pop_data;
    logic [QW-1:0]       pop_word;

    pipc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_vertex_x    (s_vertex_x),
        .s_vertex_y    (s_vertex_y),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_last_vertex (s_last_vertex),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_ctrl        (push_ctrl),
        .q_data        (push_data)
    );

    pipc_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_push   (q_push),
        .in_ready  (q_ready),
        .in_data   ({push_ctrl, push_data}),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (pop_word)
    );

    assign pop_ctrl = pipc_ctrl_t'(pop_word[QW-1:DATA_W]);
    assign pop_data = pop_word[DATA_W-1:0];

    pipc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_ctrl       (pop_ctrl),
        .q_data       (pop_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res)
    );

endmodule

`default_nettype wire

// ===== verif/point_in_polygon_crossing_test_core_tb.sv =====
`timescale 1ns / 1ps

module point_in_polygon_crossing_test_core_tb;

    localparam int COORD_BITS = 32;
    localparam int N_ITEMS    = 1350;
    localparam int CALM_ITEMS = 150;

    typedef logic signed [COORD_BITS-1:0]   coord_t;
    typedef logic signed [2*COORD_BITS+3:0] prod_t;

    typedef struct {
        coord_t vx;
        coord_t vy;
        coord_t px;
        coord_t py;
        logic   last;
    } vertex_t;

    typedef struct {
        vertex_t v;
        bit      known;
        bit      in_poly;
    } dir_row_t;

    localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t ONE   = 32'sh0001_0000;

    logic   aclk;
    logic   aresetn       = 1'b0;
    logic   s_valid       = 1'b0;
    wire    s_ready;
    coord_t s_vertex_x    = '0;
    coord_t s_vertex_y    = '0;
    coord_t s_point_x     = '0;
    coord_t s_point_y     = '0;
    logic   s_last_vertex = 1'b0;
    wire    m_valid;
    logic   m_ready       = 1'b1;
    wire    m_inside_res;

    point_in_polygon_crossing_test_core #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_vertex_x   (s_vertex_x),
        .s_vertex_y   (s_vertex_y),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_last_vertex(s_last_vertex),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res)
    );

    // Polygon tracker state
    coord_t first_x  = '0;
    coord_t first_y  = '0;
    coord_t prev_x   = '0;
    coord_t prev_y   = '0;
    coord_t qry_x    = '0;
    coord_t qry_y    = '0;
    bit     parity   = 1'b0;
    bit     mid_poly = 1'b0;

    bit       inside_q[$];
    dir_row_t dir_rows[$];

    bit idle_en    = 1'b1;
    int stall_left = 0;
    int n_fail     = 0;
    int n_vertices = 0;
    int n_polys    = 0;
    int n_results  = 0;
    int n_inside   = 0;
    bit exp_inside;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("point_in_polygon_crossing_test_core_tb: FAIL");
        $finish;
    end

    // Edge A-B flips parity when it straddles the query y and crosses strictly right of
    // the query x. Cross-multiply with the sign of dy folded into the compare direction.
    function automatic bit edge_flips(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        prod_t w_ax, w_ay, w_bx, w_by, w_qx, w_qy;
        prod_t dy, lhs, rhs;
        bit    a_up, b_up;
        a_up = ay > qry_y;
        b_up = by > qry_y;
        if (a_up == b_up)
            return 1'b0;
        w_ax = ax;
        w_ay = ay;
        w_bx = bx;
        w_by = by;
        w_qx = qry_x;
        w_qy = qry_y;
        dy  = w_by - w_ay;
        lhs = (w_qx - w_ax) * dy;
        rhs = (w_bx - w_ax) * (w_qy - w_ay);
        return (dy < 0) ? (rhs < lhs) : (lhs < rhs);
    endfunction

    function automatic bit step_polygon(vertex_t v, output bit in_poly);
        in_poly = 1'b0;
        if (!mid_poly) begin
            qry_x    = v.px;
            qry_y    = v.py;
            first_x  = v.vx;
            first_y  = v.vy;
            parity   = 1'b0;
            mid_poly = 1'b1;
        end else if (edge_flips(v.vx, v.vy, prev_x, prev_y)) begin
            parity = ~parity;
        end
        prev_x = v.vx;
        prev_y = v.vy;
        if (!v.last)
            return 1'b0;
        // closing edge back to the first vertex
        if (edge_flips(v.vx, v.vy, first_x, first_y))
            parity = ~parity;
        in_poly  = parity;
        mid_poly = 1'b0;
        n_polys++;
        return 1'b1;
    endfunction

    function automatic void add_row(coord_t vx, coord_t vy, coord_t px, coord_t py,
                                    bit last, bit known = 1'b0, bit in_poly = 1'b0);
        dir_row_t r;
        r.v.vx    = vx;
        r.v.vy    = vy;
        r.v.px    = px;
        r.v.py    = py;
        r.v.last  = last;
        r.known   = known;
        r.in_poly = in_poly;
        dir_rows.push_back(r);
    endfunction

    // 0: full range, 1: raw lsb grid (ties), 2: Q16.16 grid with fraction,
    // 3: extremes, 4: mix of all per coordinate
    function automatic coord_t pick_coord(int style);
        int k;
        if (style == 4)
            style = $urandom_range(0, 3);
        case (style)
            0: return $urandom;
            1: return coord_t'(int'($urandom_range(0, 16)) - 8);
            2: begin
                k = int'($urandom_range(0, 16)) - 8;
                return coord_t'(k * 65536 + int'($urandom_range(0, 65535)));
            end
            default: begin
                case ($urandom_range(0, 6))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return C_MIN + 1;
                    3: return C_MAX - 1;
                    4: return -1;
                    5: return 1;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    task automatic push_vertex(vertex_t v, bit known, bit known_inside);
        bit has_res;
        bit pred_inside;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_vertex_x    <= v.vx;
        s_vertex_y    <= v.vy;
        s_point_x     <= v.px;
        s_point_y     <= v.py;
        s_last_vertex <= v.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_vertices++;
        has_res = step_polygon(v, pred_inside);
        if (has_res)
            inside_q.push_back(known ? known_inside : pred_inside);
    endtask

    // Result checker and sink stall generator
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (inside_q.size() == 0) begin
                $error("inside_res: no result expected, got %0b", m_inside_res);
                n_fail++;
            end else begin
                exp_inside = inside_q.pop_front();
                if (m_inside_res !== exp_inside) begin
                    $error("inside_res: expected %0b, got %0b", exp_inside, m_inside_res);
                    n_fail++;
                end
                n_results++;
                n_inside += exp_inside;
            end
        end
        if (idle_en && stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_en && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 13);
            m_ready    <= 1'b0;
        end else begin
            stall_left <= 0;
            m_ready    <= 1'b1;
        end
    end

    initial begin
        coord_t  vxs[$];
        coord_t  vys[$];
        coord_t  px, py;
        vertex_t v;
        int      nv, sel, style;

        // single vertex: degenerate closing edge never straddles
        add_row('0, '0, '0, '0, 1'b1, 1'b1, 1'b0);
        add_row(C_MIN, C_MAX, C_MAX, C_MIN, 1'b1, 1'b1, 1'b0);
        // 2x2 square around the origin, query at the center; junk query on later vertices
        add_row(-ONE, -ONE, '0, '0, 1'b0);
        add_row(ONE, -ONE, C_MAX, C_MIN, 1'b0);
        add_row(ONE, ONE, C_MIN, C_MAX, 1'b0);
        add_row(-ONE, ONE, -1, -1, 1'b1, 1'b1, 1'b1);
        // same square, query right of both vertical edges
        add_row(-ONE, -ONE, 2*ONE, '0, 1'b0);
        add_row(ONE, -ONE, '0, '0, 1'b0);
        add_row(ONE, ONE, '0, '0, 1'b0);
        add_row(-ONE, ONE, '0, '0, 1'b1, 1'b1, 1'b0);
        // horizontal base on the query line
        add_row('0, '0, ONE, '0, 1'b0);
        add_row(4*ONE, '0, C_MAX, C_MAX, 1'b0);
        add_row('0, 4*ONE, C_MIN, C_MIN, 1'b1);
        // query exactly on the left edge crossing
        add_row(-ONE, -ONE, -ONE, '0, 1'b0);
        add_row(ONE, -ONE, '0, '0, 1'b0);
        add_row(ONE, ONE, '0, '0, 1'b0);
        add_row(-ONE, ONE, '0, '0, 1'b1);
        // full-range triangle: widest products
        add_row(C_MIN, C_MIN, '0, '0, 1'b0);
        add_row(C_MAX, C_MIN, '0, '0, 1'b0);
        add_row(C_MIN, C_MAX, '0, '0, 1'b1);
        // two-vertex polygon across the whole range
        add_row(C_MAX, C_MIN, C_MIN, '0, 1'b0);
        add_row(C_MIN, C_MAX, C_MAX, C_MAX, 1'b1);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            push_vertex(dir_rows[i].v, dir_rows[i].known, dir_rows[i].in_poly);

        while (n_vertices < N_ITEMS) begin
            idle_en = (n_vertices < N_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                nv = $urandom_range(1, 2);
            else if (sel == 9)
                nv = $urandom_range(9, 24);
            else
                nv = $urandom_range(3, 8);
            style = $urandom_range(0, 4);
            vxs.delete();
            vys.delete();
            for (int k = 0; k < nv; k++) begin
                vxs.push_back(pick_coord(style));
                vys.push_back(pick_coord(style));
            end
            px = pick_coord(style);
            py = pick_coord(style);
            // land the query on vertex rows and columns to hit the tie cases
            if ($urandom_range(0, 3) == 0)
                py = vys[$urandom_range(0, nv-1)];
            if ($urandom_range(0, 4) == 0)
                px = vxs[$urandom_range(0, nv-1)];
            for (int k = 0; k < nv; k++) begin
                v.vx   = vxs[k];
                v.vy   = vys[k];
                v.px   = (k == 0) ? px : coord_t'($urandom);
                v.py   = (k == 0) ? py : coord_t'($urandom);
                v.last = (k == nv - 1);
                push_vertex(v, 1'b0, 1'b0);
            end
        end
        idle_en = 1'b0;
        s_valid <= 1'b0;

        while (inside_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d vertices in %0d polygons, %0d results checked (%0d inside)",
                 n_vertices, n_polys, n_results, n_inside);
        if (n_fail == 0) begin
            $display("point_in_polygon_crossing_test_core_tb: PASS");
        end else begin
            $display("point_in_polygon_crossing_test_core_tb: FAIL");
        end
        $finish;
    end

endmodule
